[hw/rtl/largest_empty_square_scan_top_macros.svh]
// Assertion helpers for the square scan; they expect clk and arst_n in scope.
`ifndef LARGEST_EMPTY_SQUARE_SCAN_TOP_MACROS_SVH
`define LARGEST_EMPTY_SQUARE_SCAN_TOP_MACROS_SVH

// same-cycle implication
`define LESQ_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define LESQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[hw/rtl/lesq_pkg.sv]
package lesq_pkg;

	localparam int unsigned SIZE_W    = 11;
	localparam int unsigned POS_W     = 10;
	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned MAX_COLS_DEF = 1024;
	localparam int unsigned MAX_ROWS_DEF = 1024;

	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CHAR_W-1:0] char_t;

	localparam size_t COLS_RST = 11'd1024;
	localparam size_t ROWS_RST = 11'd1024;
	localparam char_t OBST_RST = 8'd111;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COLS = 2'd0,
		CFG_ROWS = 2'd1,
		CFG_OBST = 2'd2
	} cfg_idx_t;

	// per-cell control carried from the counter stage to the score stage
	typedef struct packed {
		logic blocked;  // cell matches the obstacle byte
		logic border;   // first row or first column
		logic eol;      // last cell of its row
		logic last;     // last cell of the grid
		pos_t row;
		pos_t col;
	} cell_info_t;

	// zero acts as one, values above the limit saturate
	function automatic size_t clamp_dim(size_t v, int unsigned limit);
		size_t r;
		r = v;
		if (v == '0)
			r = size_t'(1);
		else if (32'(v) > limit)
			r = size_t'(limit);
		return r;
	endfunction

endpackage

[hw/rtl/lesq_ram.sv]
module lesq_ram #(
	parameter int unsigned WIDTH = 11,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/lesq_cnt.sv]
module lesq_cnt #(
	parameter int unsigned MAX_COLS = 1024,
	parameter int unsigned MAX_ROWS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cell_valid,
	output logic                        cell_ready,
	input  lesq_pkg::char_t             cell_char,
	input  lesq_pkg::size_t             cols_cfg,
	input  lesq_pkg::size_t             rows_cfg,
	input  lesq_pkg::char_t             obst,
	input  logic                        s1_adv,
	output logic                        s1_valid,
	output lesq_pkg::cell_info_t        s1_info,
	output logic                        rd_en,
	output logic [$clog2(MAX_COLS)-1:0] rd_addr
);
	import lesq_pkg::*;

	localparam int unsigned AW = $clog2(MAX_COLS);

	pos_t       col_q, row_q;
	logic       s1_valid_q;
	cell_info_t info_s1;
	size_t      cols, rows, col_inc, row_inc;
	logic       accept, eol, last;

	assign cols    = clamp_dim(cols_cfg, MAX_COLS);
	assign rows    = clamp_dim(rows_cfg, MAX_ROWS);
	assign col_inc = {1'b0, col_q} + size_t'(1);
	assign row_inc = {1'b0, row_q} + size_t'(1);
	assign eol     = col_inc >= cols;
	assign last    = eol && (row_inc >= rows);

	assign cell_ready = !s1_valid_q || s1_adv;
	assign accept     = cell_valid && cell_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (cell_ready) begin
				s1_valid_q <= accept;
			end
			if (accept) begin
				col_q <= eol ? '0 : col_inc[POS_W-1:0];
				if (eol) begin
					row_q <= last ? '0 : row_inc[POS_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1.blocked <= (cell_char == obst);
			info_s1.border  <= (row_q == '0) || (col_q == '0);
			info_s1.eol     <= eol;
			info_s1.last    <= last;
			info_s1.row     <= row_q;
			info_s1.col     <= col_q;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1_info  = info_s1;
	assign rd_en    = accept;
	assign rd_addr  = AW'(col_q);

endmodule

[hw/rtl/lesq_score.sv]
module lesq_score #(
	parameter int unsigned AW = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s1_valid,
	input  lesq_pkg::cell_info_t s1_info,
	input  lesq_pkg::size_t      up,
	output logic                 s1_adv,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output lesq_pkg::size_t      wr_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lesq_pkg::size_t      best_size,
	output lesq_pkg::pos_t       best_row,
	output lesq_pkg::pos_t       best_col
);
	import lesq_pkg::*;

	size_t            left_q, diag_q, best_size_q, out_size_q, m, score;
	pos_t             best_row_q, best_col_q, out_row_q, out_col_q;
	logic             out_valid_q, commit, better;
	logic [SIZE_W:0]  sum;

	always_comb begin
		m = left_q;
		if (up < m)
			m = up;
		if (diag_q < m)
			m = diag_q;
	end

	assign sum = {1'b0, m} + (SIZE_W+1)'(1);

	always_comb begin
		if (s1_info.blocked)
			score = '0;
		else if (s1_info.border)
			score = size_t'(1);
		else if (sum[SIZE_W])
			score = '1;
		else
			score = sum[SIZE_W-1:0];
	end

	// a grid-ending cell waits only while the result register is still full
	assign s1_adv = !(s1_info.last && out_valid_q && !out_ready);
	assign commit = s1_valid && s1_adv;
	assign better = score > best_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			diag_q      <= '0;
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit && s1_info.last)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (commit) begin
				left_q <= s1_info.eol ? '0 : score;
				diag_q <= s1_info.eol ? '0 : up;
				if (s1_info.last) begin
					best_size_q <= '0;
					best_row_q  <= '0;
					best_col_q  <= '0;
				end else if (better) begin
					best_size_q <= score;
					best_row_q  <= s1_info.row;
					best_col_q  <= s1_info.col;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && s1_info.last) begin
			out_size_q <= better ? score : best_size_q;
			out_row_q  <= better ? s1_info.row : best_row_q;
			out_col_q  <= better ? s1_info.col : best_col_q;
		end
	end

	assign wr_en     = commit;
	assign wr_addr   = AW'(s1_info.col);
	assign wr_data   = score;
	assign out_valid = out_valid_q;
	assign best_size = out_size_q;
	assign best_row  = out_row_q;
	assign best_col  = out_col_q;

endmodule

[hw/rtl/largest_empty_square_scan_top.sv]
// Largest empty square scan. Grid cells stream in row-major order, one per
// transfer on cell_req; after the last cell of a grid one result transfer gives
// the side of the largest square free of obstacle_char and its bottom-right
// row and column (size 0 at 0,0 if every cell is blocked). The sustained rate
// is one cell per clock, barring a grid-end stall: each cell takes one read and one
// write of the previous-row line buffer (a single RAM of MAX_COLS entries), read on
// accept and written back as the cell leaves the score stage. The result is
// registered once the last cell commits; input keeps flowing while a result waits,
// until the last cell of the next grid, which holds until the result is taken. The
// user must write grid size and obstacle registers only while idle (unenforced).
module largest_empty_square_scan_top #(
	parameter int unsigned MAX_COLS = lesq_pkg::MAX_COLS_DEF,
	parameter int unsigned MAX_ROWS = lesq_pkg::MAX_ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [lesq_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  lesq_pkg::size_t                   cfg_wr_data,
	input  logic                              cell_req_valid,
	output logic                              cell_req_ready,
	input  lesq_pkg::char_t                   cell_req,
	output logic                              result_valid,
	input  logic                              result_ready,
	output lesq_pkg::size_t                   best_size,
	output lesq_pkg::pos_t                    best_row,
	output lesq_pkg::pos_t                    best_col
);
	import lesq_pkg::*;

	`include "largest_empty_square_scan_top_macros.svh"

	localparam int unsigned AW = $clog2(MAX_COLS);

	size_t      cols_q, rows_q, up, wr_data;
	char_t      obst_q;
	logic       s1_valid, s1_adv, rd_en, wr_en;
	cell_info_t s1_info;
	logic [AW-1:0] rd_addr, wr_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RST;
			rows_q <= ROWS_RST;
			obst_q <= OBST_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_COLS: cols_q <= cfg_wr_data;
				CFG_ROWS: rows_q <= cfg_wr_data;
				CFG_OBST: obst_q <= cfg_wr_data[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	lesq_cnt #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_cnt (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_valid(cell_req_valid),
		.cell_ready(cell_req_ready),
		.cell_char (cell_req),
		.cols_cfg  (cols_q),
		.rows_cfg  (rows_q),
		.obst      (obst_q),
		.s1_adv    (s1_adv),
		.s1_valid  (s1_valid),
		.s1_info   (s1_info),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr)
	);

	lesq_ram #(
		.WIDTH(SIZE_W),
		.DEPTH(MAX_COLS)
	) u_line (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(up)
	);

	lesq_score #(
		.AW(AW)
	) u_score (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.s1_info  (s1_info),
		.up       (up),
		.s1_adv   (s1_adv),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.out_valid(result_valid),
		.out_ready(result_ready),
		.best_size(best_size),
		.best_row (best_row),
		.best_col (best_col)
	);

	// the cell stage only stalls behind an unclaimed result
	`LESQ_ASSERT_SAME(a_stall_cause, s1_valid && !s1_adv, result_valid, "cell stage stalled without a pending result")
	// a committed last cell always produces a result next cycle
	`LESQ_ASSERT_NEXT(a_last_result, s1_valid && s1_adv && s1_info.last, result_valid, "grid end gave no result")
	// same-entry overlap of read and write happens only at column zero, whose value is unused
	`LESQ_ASSERT_SAME(a_line_overlap, wr_en && rd_en && (rd_addr == wr_addr), rd_addr == '0, "line buffer read/write collision")

endmodule
